### rtl/cbbp_pkg.sv
// cbbp_pkg: shared types, constants and command/status structs
// for the component bounding-box perimeter block; no dependencies
`timescale 1ns / 1ps
package cbbp_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int COORD_BITS_DEF = 27;
  localparam int IDX_BITS       = 10;
  localparam int PERIM_BITS     = 29;
  localparam int FCOORD_BITS    = 27;

  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [FCOORD_BITS-1:0] point_x;
    logic [FCOORD_BITS-1:0] point_y;
    logic [IDX_BITS-1:0]    end_a;
    logic [IDX_BITS-1:0]    end_b;
  } in_req_t;

  typedef struct packed {
    logic [PERIM_BITS-1:0] min_perimeter;
    logic [1:0]            status;
  } out_res_t;

  // datapath address source select
  localparam logic [2:0] ASEL_COUNT = 3'd0;
  localparam logic [2:0] ASEL_A     = 3'd1;
  localparam logic [2:0] ASEL_B     = 3'd2;
  localparam logic [2:0] ASEL_CUR   = 3'd3;
  localparam logic [2:0] ASEL_KEEP  = 3'd4;
  localparam logic [2:0] ASEL_GONE  = 3'd5;
  localparam logic [2:0] ASEL_SCAN  = 3'd6;

  typedef struct packed {
    logic       load_req;     // latch request fields
    logic [2:0] addr_sel;     // address for memory reads/writes
    logic       wr_point;     // write new node at count
    logic       wr_parent;    // parent[gone] = keep
    logic       wr_box;       // box[keep] = merged box
    logic       cur_from_a;   // cur = a
    logic       cur_from_b;   // cur = b
    logic       cur_step;     // cur = parent read
    logic       save_ra;      // ra = cur
    logic       save_rb;      // rb = cur
    logic       save_keep;    // latch keep box from read data
    logic       count_inc;
    logic       err_set;
    logic       scan_clr;
    logic       scan_inc;
    logic       scan_eval;    // fold read data into best
    logic       finish;       // emit result and clear counters
  } cbbp_cmd_t;

  typedef struct packed {
    logic full;
    logic edge_bad;
    logic at_root;        // parent read equals cur
    logic roots_same;
    logic scan_done;      // nothing loaded, scan has no entries
    logic scan_last;      // scan index is count-1
  } cbbp_sts_t;

endpackage

### rtl/cbbp_ram.sv
// cbbp_ram: generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
module cbbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/cbbp_datapath.sv
// cbbp_datapath: node memories, union-find walk registers, scan min
// depends on cbbp_pkg and cbbp_ram
`timescale 1ns / 1ps
module cbbp_datapath import cbbp_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_req,
  input  cbbp_cmd_t cmd,
  output cbbp_sts_t sts,
  output out_res_t  res
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int BW = 4 * COORD_BITS;

  logic [CW-1:0] count_r, count_nxt;
  logic          err_r, err_nxt;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [IDX_BITS-1:0]   ea_r, eb_r;
  logic [AW-1:0] cur_r, ra_r, rb_r, scan_r;
  logic [BW-1:0] keep_box_r;
  logic [COORD_BITS+2:0] best_r;
  logic          have_r;

  logic [AW-1:0] addr, keep, gone;
  logic [AW-1:0] par_rd;
  logic [BW-1:0] box_rd, box_wd, merged;
  logic          par_we, box_we;
  logic [AW-1:0] par_wd;
  logic [COORD_BITS-1:0] kmnx, kmny, kmxx, kmxy, gmnx, gmny, gmxx, gmxy;
  logic [COORD_BITS:0]   w, h;
  logic [COORD_BITS+2:0] perim;

  assign keep = (ra_r < rb_r) ? ra_r : rb_r;
  assign gone = (ra_r < rb_r) ? rb_r : ra_r;

  always_comb begin
    case (cmd.addr_sel)
      ASEL_COUNT: addr = count_r[AW-1:0];
      ASEL_A:     addr = AW'(ea_r);
      ASEL_B:     addr = AW'(eb_r);
      ASEL_CUR:   addr = cur_r;
      ASEL_KEEP:  addr = keep;
      ASEL_GONE:  addr = gone;
      ASEL_SCAN:  addr = scan_r;
      default:    addr = cur_r;
    endcase
  end

  assign {kmnx, kmny, kmxx, kmxy} = keep_box_r;
  assign {gmnx, gmny, gmxx, gmxy} = box_rd;
  assign merged = {(kmnx < gmnx) ? kmnx : gmnx, (kmny < gmny) ? kmny : gmny,
                   (kmxx > gmxx) ? kmxx : gmxx, (kmxy > gmxy) ? kmxy : gmxy};

  assign par_we = cmd.wr_point | cmd.wr_parent;
  assign par_wd = cmd.wr_point ? count_r[AW-1:0] : keep;
  assign box_we = cmd.wr_point | cmd.wr_box;
  assign box_wd = cmd.wr_point ? {px_r, py_r, px_r, py_r} : merged;

  cbbp_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(addr), .wdata(par_wd),
    .raddr(addr), .rdata(par_rd));

  cbbp_ram #(.WIDTH(BW), .DEPTH(MAX_NODES)) u_box (
    .clk(clk), .we(box_we), .waddr(addr), .wdata(box_wd),
    .raddr(addr), .rdata(box_rd));

  // perimeter of the scanned entry, kept full width until the output
  assign w     = {1'b0, gmxx} - {1'b0, gmnx};
  assign h     = {1'b0, gmxy} - {1'b0, gmny};
  assign perim = {({1'b0, w} + {1'b0, h}), 1'b0};

  always_comb begin
    count_nxt = count_r;
    err_nxt   = err_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.err_set) begin
      err_nxt = 1'b1;
    end
    if (cmd.finish) begin
      count_nxt = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (cmd.scan_clr) begin
        have_r <= 1'b0;
      end else if (cmd.scan_eval && par_rd == scan_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      px_r   <= COORD_BITS'(in_req.point_x);
      py_r   <= COORD_BITS'(in_req.point_y);
      ea_r   <= in_req.end_a;
      eb_r   <= in_req.end_b;
    end
    if (cmd.cur_from_a) begin
      cur_r <= AW'(ea_r);
    end else if (cmd.cur_from_b) begin
      cur_r <= AW'(eb_r);
    end else if (cmd.cur_step) begin
      cur_r <= par_rd;
    end
    if (cmd.save_ra) begin
      ra_r <= cur_r;
    end
    if (cmd.save_rb) begin
      rb_r <= cur_r;
    end
    if (cmd.save_keep) begin
      keep_box_r <= box_rd;
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
      best_r <= '0;
    end else begin
      if (cmd.scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.scan_eval && par_rd == scan_r && (!have_r || perim < best_r)) begin
        best_r <= perim;
      end
    end
  end

  assign sts.full       = (count_r == CW'(MAX_NODES));
  assign sts.edge_bad   = (32'(ea_r) >= 32'(count_r)) ||
                          (32'(eb_r) >= 32'(count_r));
  assign sts.at_root    = (par_rd == cur_r);
  assign sts.roots_same = (ra_r == rb_r);
  assign sts.scan_done  = (count_r == '0);
  assign sts.scan_last  = ((CW)'(scan_r) + 1'b1 == count_r);

  assign res.min_perimeter = PERIM_BITS'(best_r);
  assign res.status = err_r ? ST_ERROR : (count_r == '0) ? ST_EMPTY : ST_OK;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_NODES))
    else $error("node count past capacity");
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> count_r == '0 && !err_r)
    else $error("finish did not clear");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(err_r) && !$past(cmd.finish) |-> err_r)
    else $error("error flag dropped");
endmodule

### rtl/cbbp_ctrl.sv
// cbbp_ctrl: sequencer for point, edge union and finish scan
// depends on cbbp_pkg
`timescale 1ns / 1ps
module cbbp_ctrl import cbbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] mode,
  input  cbbp_sts_t sts,
  output logic      busy,
  output logic      out_valid,
  output cbbp_cmd_t cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_WA_RD  = 4'd2;
  localparam logic [3:0] S_WA_CHK = 4'd3;
  localparam logic [3:0] S_WB_RD  = 4'd4;
  localparam logic [3:0] S_WB_CHK = 4'd5;
  localparam logic [3:0] S_MG_RK  = 4'd6;
  localparam logic [3:0] S_MG_RG  = 4'd7;
  localparam logic [3:0] S_MG_LK  = 4'd8;
  localparam logic [3:0] S_MG_WR  = 4'd9;
  localparam logic [3:0] S_SC_RD  = 4'd10;
  localparam logic [3:0] S_SC_EV  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_WA_ST  = 4'd13;
  localparam logic [3:0] S_WB_ST  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mode_r;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_POINT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (start && !busy) begin
        mode_r <= mode;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.addr_sel  = ASEL_CUR;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        case (mode_r)
          MODE_POINT: begin
            if (sts.full) begin
              cmd.err_set = 1'b1;
            end else begin
              cmd.addr_sel  = ASEL_COUNT;
              cmd.wr_point  = 1'b1;
              cmd.count_inc = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          MODE_EDGE: begin
            if (sts.edge_bad) begin
              cmd.err_set = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.cur_from_a = 1'b1;
              state_nxt      = S_WA_RD;
            end
          end
          MODE_FINISH: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SC_RD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // root walk for a: read parent, then compare
      S_WA_RD: begin
        state_nxt = S_WA_CHK;
      end
      S_WA_CHK: begin
        if (sts.at_root) begin
          cmd.save_ra    = 1'b1;
          state_nxt      = S_WA_ST;
        end else begin
          cmd.cur_step = 1'b1;
          state_nxt    = S_WA_RD;
        end
      end
      S_WA_ST: begin
        cmd.cur_from_b = 1'b1;
        state_nxt      = S_WB_RD;
      end
      S_WB_RD: begin
        state_nxt = S_WB_CHK;
      end
      S_WB_CHK: begin
        if (sts.at_root) begin
          cmd.save_rb = 1'b1;
          state_nxt   = S_WB_ST;
        end else begin
          cmd.cur_step = 1'b1;
          state_nxt    = S_WB_RD;
        end
      end
      S_WB_ST: begin
        state_nxt = sts.roots_same ? S_IDLE : S_MG_RK;
      end
      S_MG_RK: begin
        cmd.addr_sel = ASEL_KEEP;
        state_nxt    = S_MG_RG;
      end
      S_MG_RG: begin
        cmd.addr_sel  = ASEL_GONE;
        cmd.save_keep = 1'b1;
        state_nxt     = S_MG_LK;
      end
      S_MG_LK: begin
        // box of gone is on the read port now
        cmd.addr_sel  = ASEL_KEEP;
        cmd.wr_box    = 1'b1;
        state_nxt     = S_MG_WR;
      end
      S_MG_WR: begin
        cmd.addr_sel  = ASEL_GONE;
        cmd.wr_parent = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SC_RD: begin
        cmd.addr_sel = ASEL_SCAN;
        if (sts.scan_done) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SC_EV;
        end
      end
      S_SC_EV: begin
        cmd.addr_sel  = ASEL_SCAN;
        cmd.scan_eval = 1'b1;
        cmd.scan_inc  = 1'b1;
        state_nxt     = sts.scan_last ? S_EMIT : S_SC_RD;
      end
      S_EMIT: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_EMIT)
    else $error("result without finish");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !cmd.wr_box && !cmd.wr_parent && !cmd.wr_point)
    else $error("memory write while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |-> state_r == S_IDLE)
    else $error("request latched while busy");
endmodule

### rtl/component_bounding_box_perimeter.sv
// component_bounding_box_perimeter: top level, controller plus datapath
// point or bad edge: decoded and done; edge: root walk of a, then of b, each hop
// a parent read and a compare, then a merge when the roots differ; finish: a scan
// of every loaded node, then the result; one request at a time (busy)
// result strobe out_valid is registered from the emit state; receiver cannot stall
// synchronous active-low reset clears node count and error flag; node
// memories are not cleared and are refilled as points arrive
`timescale 1ns / 1ps
module component_bounding_box_perimeter import cbbp_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);
  cbbp_cmd_t cmd;
  cbbp_sts_t sts;
  out_res_t  res;

  cbbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_req.mode),
    .sts(sts), .busy(busy), .out_valid(out_valid), .cmd(cmd));

  cbbp_datapath #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts), .res(res));

  // hold result captured at the finish cycle
  out_res_t res_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= res;
    end
  end
  assign out_res = res_r;
endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for component_bounding_box_perimeter
// drives point/edge/finish requests, predicts results with a union-find model
`timescale 1ns / 1ps
module tb_top;
  import cbbp_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;

  always #1 clk = ~clk;

  component_bounding_box_perimeter u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // predictor state
  logic [26:0] bx_lo [NODES];
  logic [26:0] bx_hi [NODES];
  logic [26:0] by_lo [NODES];
  logic [26:0] by_hi [NODES];
  int unsigned link_of [NODES];
  int unsigned loaded;
  bit err_flag;

  out_res_t perim_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int unsigned root_of(int unsigned v);
    while (link_of[v] != v) v = link_of[v];
    return v;
  endfunction

  task automatic predict_request(in_req_t r);
    int unsigned ra, rb, keep, gone;
    logic [63:0] w, h, p, best;
    bit have;
    out_res_t res;
    case (r.mode)
      MODE_POINT: begin
        if (loaded >= NODES) err_flag = 1;
        else begin
          bx_lo[loaded] = r.point_x; bx_hi[loaded] = r.point_x;
          by_lo[loaded] = r.point_y; by_hi[loaded] = r.point_y;
          link_of[loaded] = loaded;
          loaded++;
        end
      end
      MODE_EDGE: begin
        if (r.end_a >= loaded || r.end_b >= loaded) err_flag = 1;
        else begin
          ra = root_of(r.end_a);
          rb = root_of(r.end_b);
          if (ra != rb) begin
            keep = ra < rb ? ra : rb;
            gone = ra < rb ? rb : ra;
            link_of[gone] = keep;
            if (bx_lo[gone] < bx_lo[keep]) bx_lo[keep] = bx_lo[gone];
            if (by_lo[gone] < by_lo[keep]) by_lo[keep] = by_lo[gone];
            if (bx_hi[gone] > bx_hi[keep]) bx_hi[keep] = bx_hi[gone];
            if (by_hi[gone] > by_hi[keep]) by_hi[keep] = by_hi[gone];
          end
        end
      end
      MODE_FINISH: begin
        best = 0; have = 0;
        for (int unsigned i = 0; i < loaded; i++) begin
          if (link_of[i] == i) begin
            w = 64'(bx_hi[i]) - 64'(bx_lo[i]);
            h = 64'(by_hi[i]) - 64'(by_lo[i]);
            p = 2 * (w + h);
            if (!have || p < best) begin best = p; have = 1; end
          end
        end
        res.min_perimeter = best[PERIM_BITS-1:0];
        res.status = err_flag ? ST_ERROR : (loaded == 0 ? ST_EMPTY : ST_OK);
        perim_q.insert(perim_q.size(), res);
        loaded = 0; err_flag = 0;
      end
      default: ;
    endcase
  endtask

  // result checking
  always @(posedge clk) begin
    out_res_t exp_r;
    if (rst_n && out_valid) begin
      if (perim_q.size() == 0) begin
        $error("result with no request pending: %0d/%0d",
               out_res.min_perimeter, out_res.status);
        errors++;
      end else begin
        exp_r = perim_q.pop_front();
        if (out_res.min_perimeter !== exp_r.min_perimeter) begin
          $error("min_perimeter expected %0d actual %0d",
                 exp_r.min_perimeter, out_res.min_perimeter);
          errors++;
        end
        if (out_res.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_res.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  task automatic send(in_req_t r);
    int unsigned gap;
    // sender may idle between bursts
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
  endtask

  function automatic in_req_t mk(logic [1:0] m, int unsigned x, int unsigned y,
                                 int unsigned a, int unsigned b);
    in_req_t r;
    r.mode = m;
    r.point_x = FCOORD_BITS'(x);
    r.point_y = FCOORD_BITS'(y);
    r.end_a = IDX_BITS'(a);
    r.end_b = IDX_BITS'(b);
    return r;
  endfunction

  function automatic in_req_t rnd_req(logic [1:0] m, int unsigned span);
    in_req_t r;
    r.mode = m;
    r.point_x = ($urandom_range(0, 3) == 0) ? FCOORD_BITS'($urandom())
                                            : FCOORD_BITS'($urandom_range(0, 1000));
    r.point_y = ($urandom_range(0, 3) == 0) ? FCOORD_BITS'($urandom())
                                            : FCOORD_BITS'($urandom_range(0, 1000));
    r.end_a = IDX_BITS'($urandom_range(0, span));
    r.end_b = IDX_BITS'($urandom_range(0, span));
    return r;
  endfunction

  typedef struct {
    in_req_t req;
    bit      typed;
    out_res_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(in_req_t req, bit typed, out_res_t want);
    dir_row_t row;
    row.req = req; row.typed = typed; row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (perim_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int set_size;
    int s;
    out_res_t r_empty, r_err, r_zero, r_max;
    r_empty = '{min_perimeter: 0, status: ST_EMPTY};
    r_err   = '{min_perimeter: 0, status: ST_ERROR};
    r_zero  = '{min_perimeter: 0, status: ST_OK};
    r_max   = '{min_perimeter: 29'd536870908, status: ST_OK};
    loaded = 0; err_flag = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 1, r_empty);
    add_row(mk(MODE_EDGE, 0, 0, 0, 0), 0, r_zero);      // bad edge
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 1, r_err);
    add_row(mk(MODE_POINT, 5, 9, 0, 0), 0, r_zero);
    add_row(mk(MODE_EDGE, 0, 0, 0, 0), 0, r_zero);      // self edge
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 1, r_zero);
    add_row(mk(MODE_POINT, 0, 0, 0, 0), 0, r_zero);
    add_row(mk(MODE_POINT, 27'h7ffffff, 27'h7ffffff, 0, 0), 0, r_zero);
    add_row(mk(MODE_EDGE, 0, 0, 1, 0), 0, r_zero);
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 1, r_max);
    add_row(mk(MODE_POINT, 10, 20, 0, 0), 0, r_zero);
    add_row(mk(MODE_POINT, 30, 5, 0, 0), 0, r_zero);
    add_row(mk(MODE_POINT, 12, 40, 0, 0), 0, r_zero);
    add_row(mk(MODE_UNUSED, 0, 0, 0, 0), 0, r_zero);
    add_row(mk(MODE_EDGE, 0, 0, 2, 1), 0, r_zero);
    add_row(mk(MODE_EDGE, 0, 0, 1, 2), 0, r_zero);     // same component
    add_row(mk(MODE_EDGE, 0, 0, 3, 1023), 0, r_zero);  // bad edge
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 0, r_zero);
    add_row(mk(MODE_POINT, 1, 2, 0, 0), 0, r_zero);
    add_row(mk(MODE_POINT, 7, 3, 0, 0), 0, r_zero);
    add_row(mk(MODE_EDGE, 0, 0, 0, 1), 0, r_zero);
    add_row(mk(MODE_FINISH, 0, 0, 0, 0), 0, r_zero);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].req);
      if (dir_rows[i].typed && perim_q.size() != 0) begin
        // the typed value stands in for the prediction
        perim_q[perim_q.size() - 1] = dir_rows[i].want;
      end
    end
    drain();

    // one set filled past capacity, with long chains for deep root walks
    for (int i = 0; i <= NODES; i++) send(rnd_req(MODE_POINT, 0));
    for (int i = 38; i >= 0; i--) send(mk(MODE_EDGE, 0, 0, i, i + 1));
    send(mk(MODE_EDGE, 0, 0, 1023, 39));
    send(mk(MODE_EDGE, 0, 0, 39, 500));
    send(mk(MODE_FINISH, 0, 0, 0, 0));
    drain();

    // random sets: mostly well formed with some noise
    sent = 0;
    while (sent < 800) begin
      set_size = $urandom_range(1, 24);
      s = 0;
      repeat ($urandom_range(0, 40)) begin
        case ($urandom_range(0, 19))
          0: send(rnd_req(MODE_UNUSED, 1023));
          1: send(rnd_req(MODE_EDGE, 1023));
          2, 3, 4, 5, 6, 7: begin
            send(rnd_req(MODE_POINT, 0)); s++;
          end
          default: begin
            if (s == 0) send(rnd_req(MODE_POINT, 0));
            else send(rnd_req(MODE_EDGE, (s > set_size) ? s - 1 : set_size - 1));
            s++;
          end
        endcase
        sent++;
      end
      send(mk(MODE_FINISH, 0, 0, 0, 0));
      sent++;
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (2200) @(posedge clk);
    if (errors == 0 && perim_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
